// File: rtl/core/ptw_pkg.sv
// ----------------------------------------------------------------------------
// Page table walker package
// Shared constants, codes and types of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  localparam int TABLE_PAGES       = 64;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int IDX_W             = 9;
  localparam int PAGE_W            = $clog2(TABLE_PAGES);
  localparam int NFP_W             = $clog2(TABLE_PAGES + 1);
  localparam int TABLE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int ADDR_W            = PAGE_W + IDX_W;
  localparam int ENTRY_W           = 64;
  localparam int PFN_W             = 40;
  localparam int VPN_W             = 36;

  localparam logic [11:0] LINK_FLAGS = 12'h007;
  localparam logic [1:0]  LVL_LEAF   = 2'd3;

  typedef enum logic [1:0] {
    FN_MAP    = 2'd0,
    FN_UNMAP  = 2'd1,
    FN_LOOKUP = 2'd2
  } ptw_func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_OOM     = 2'd2
  } ptw_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } ptw_state_e;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } ptw_mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [PFN_W-1:0] pfn;
    ptw_status_e      status;
  } ptw_res_t;

  function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                   input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      2'd0:    idx = vpn[35:27];
      2'd1:    idx = vpn[26:18];
      2'd2:    idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
    return idx;
  endfunction

endpackage

// File: rtl/core/ptw_ram.sv
// ----------------------------------------------------------------------------
// Page table pool RAM
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/ptw_walk.sv
// ----------------------------------------------------------------------------
// Page table walk sequencer
// Clears the pool after reset, then walks the four levels of each map, unmap
// or lookup request through the pool RAM, allocating missing levels on a map.
// ----------------------------------------------------------------------------
module ptw_walk
  import ptw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           func_i,
  input  logic [47:0]          virt_addr_i,
  input  logic [51:0]          phys_addr_i,
  input  logic [11:0]          page_flags_i,
  output ptw_res_t             res_o,
  input  logic                 res_take_i,
  output ptw_mem_req_t         mem_o,
  input  logic [ENTRY_W-1:0]   mem_rdata_i
);

  ptw_state_e        state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [NFP_W-1:0]  nfp_q, nfp_d;
  logic [PAGE_W-1:0] page_q, page_d;
  logic [1:0]        lvl_q, lvl_d;
  logic [1:0]        func_q, func_d;
  logic [VPN_W-1:0]  vpn_q, vpn_d;
  logic [PFN_W-1:0]  pa_q, pa_d;
  logic [11:0]       flags_q, flags_d;
  logic [PFN_W-1:0]  res_pfn_q, res_pfn_d;
  ptw_status_e       status_q, status_d;
  logic [PFN_W-1:0]  entry_pfn;

  assign entry_pfn = mem_rdata_i[51:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      nfp_q   <= NFP_W'(1);
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      nfp_q   <= nfp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q    <= page_d;
    lvl_q     <= lvl_d;
    func_q    <= func_d;
    vpn_q     <= vpn_d;
    pa_q      <= pa_d;
    flags_q   <= flags_d;
    res_pfn_q <= res_pfn_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    nfp_d      = nfp_q;
    page_d     = page_q;
    lvl_d      = lvl_q;
    func_d     = func_q;
    vpn_d      = vpn_q;
    pa_d       = pa_q;
    flags_d    = flags_q;
    res_pfn_d  = res_pfn_q;
    status_d   = status_q;
    mem_o.we    = 1'b0;
    mem_o.addr  = {page_q, level_index(vpn_q, lvl_q)};
    mem_o.wdata = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_o.we   = 1'b1;
        mem_o.addr = clr_q;
        clr_d      = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          func_d    = func_i;
          vpn_d     = virt_addr_i[47:12];
          pa_d      = phys_addr_i[51:12];
          flags_d   = page_flags_i;
          page_d    = '0;
          lvl_d     = '0;
          res_pfn_d = '0;
          if (func_i == FN_MAP || func_i == FN_UNMAP || func_i == FN_LOOKUP) begin
            status_d = STAT_OK;
            state_d  = S_READ;
          end else begin
            status_d = STAT_MISSING;
            state_d  = S_DONE;
          end
        end
      end
      S_READ: begin
        state_d = S_EVAL;
      end
      S_EVAL: begin
        if (lvl_q != LVL_LEAF) begin
          if (mem_rdata_i[0]) begin
            if (entry_pfn >= PFN_W'(TABLE_PAGES)) begin
              status_d = STAT_MISSING;
              state_d  = S_DONE;
            end else begin
              page_d  = mem_rdata_i[12 +: PAGE_W];
              lvl_d   = lvl_q + 2'd1;
              state_d = S_READ;
            end
          end else if (func_q != FN_MAP) begin
            status_d = STAT_MISSING;
            state_d  = S_DONE;
          end else if (nfp_q >= NFP_W'(TABLE_PAGES)) begin
            status_d = STAT_OOM;
            state_d  = S_DONE;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.wdata = {12'b0, PFN_W'(nfp_q), LINK_FLAGS};
            page_d      = nfp_q[PAGE_W-1:0];
            nfp_d       = nfp_q + NFP_W'(1);
            lvl_d       = lvl_q + 2'd1;
            state_d     = S_READ;
          end
        end else begin
          state_d = S_DONE;
          priority if (func_q == FN_MAP) begin
            mem_o.we    = 1'b1;
            mem_o.wdata = {12'b0, pa_q, flags_q};
          end else if (func_q == FN_UNMAP) begin
            mem_o.we    = 1'b1;
            mem_o.wdata = '0;
          end else if (mem_rdata_i[0]) begin
            res_pfn_d = entry_pfn;
          end else begin
            status_d = STAT_MISSING;
          end
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.pfn    = res_pfn_q;
  assign res_o.status = status_q;

`ifndef ASSERT_OFF
  a_nfp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfp_q <= NFP_W'(TABLE_PAGES))
    else $error("Allocator ran past the end of the pool.");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (state_q == S_CLEAR || state_q == S_EVAL))
    else $error("Pool write outside the clear pass or a walk step.");

  a_oom_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status == STAT_OOM) |-> (func_q == FN_MAP))
    else $error("Out-of-pages status on a request that does not allocate.");

  a_pfn_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.pfn != '0) |-> (func_q == FN_LOOKUP && res_o.status == STAT_OK))
    else $error("Nonzero address returned by something other than a good lookup.");

  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfp_q != $past(nfp_q)) |-> ($past(state_q) == S_EVAL && state_q == S_READ))
    else $error("Allocator advanced outside a walk step.");
`endif

endmodule

// File: rtl/core/four_level_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// Four-level page table walker core
// Maps, unmaps and looks up 48-bit virtual addresses in an on-chip pool of
// 512-entry table pages.
//
// The request channel carries func_i, virt_addr_i, phys_addr_i and
// page_flags_i; a transaction completes when in_valid_i is high and
// in_stall_o is low. The response channel carries result_phys_o and status_o
// and completes when out_valid_o is high and out_stall_i is low.
// One request is processed at a time. Each walked level is a pool RAM read
// followed by the evaluation of its data; walks that stop early, on a missing
// entry or an exhausted pool, walk fewer levels.
// After reset the core clears all 32768 pool entries, one per cycle, and
// holds in_stall_o high while it does so. A finished response sits in an
// output register; while the receiver stalls it holds, and the core can
// still take the next request and walk it up to its own response.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_core
  import ptw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [47:0] virt_addr_i,
  input  logic [51:0] phys_addr_i,
  input  logic [11:0] page_flags_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [51:0] result_phys_o,
  output logic [1:0]  status_o
);

  ptw_res_t           res;
  ptw_mem_req_t       mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               res_take;
  logic               out_valid_q, out_valid_d;
  logic [PFN_W-1:0]   out_pfn_q;
  logic [1:0]         out_status_q;

  ptw_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .virt_addr_i  (virt_addr_i),
    .phys_addr_i  (phys_addr_i),
    .page_flags_i (page_flags_i),
    .res_o        (res),
    .res_take_i   (res_take),
    .mem_o        (mem_req),
    .mem_rdata_i  (mem_rdata)
  );

  ptw_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  assign res_take = res.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_pfn_q    <= res.pfn;
      out_status_q <= res.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_phys_o = {out_pfn_q, 12'b0};
  assign status_o      = out_status_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker core testbench
// Sends map, unmap, lookup and reserved-function requests to the walker and
// checks every response against a table model kept in a small scoreboard.
// The stimulus shares index fields between requests so that walks reuse
// tables and the page pool runs out. Both channels idle at random, and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import ptw_pkg::*;

  localparam logic [1:0] FN_RESERVED    = 2'd3;
  localparam int         TOTAL_ITEMS    = 1350;
  localparam int         QUIET_ITEMS    = 200;
  localparam int         PRESSURE_AT    = 400;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         WATCHDOG_LIMIT = 4 * TABLE_DEPTH;
  localparam int         MAX_REPORTED   = 10;

  class page_walk_checker;
    bit [63:0]   tables [TABLE_DEPTH];
    int unsigned free_page;
    logic [51:0] expected_phys_q [$];
    logic [1:0]  expected_status_q [$];
    int          mismatches;
    int          checked;
    int          func_count [4];
    int          status_count [3];

    function new();
      free_page = 1;
    endfunction

    // Walks the model tables for one request and queues the response it owes.
    function void note_request(logic [1:0] fn, logic [47:0] va, logic [51:0] pa,
                               logic [11:0] flags);
      int          page;
      int          slot;
      int          lvl;
      bit          missing;
      bit          oom;
      logic [63:0] entry;
      logic [51:0] phys;
      logic [1:0]  st;
      page    = 0;
      missing = 0;
      oom     = 0;
      phys    = '0;
      st      = STAT_OK;
      func_count[fn]++;
      if (fn == FN_RESERVED) begin
        st = STAT_MISSING;
      end else begin
        for (lvl = 0; lvl < 3 && !missing && !oom; lvl++) begin
          slot  = page * ENTRIES_PER_TABLE + int'(va[47 - 9 * lvl -: 9]);
          entry = tables[slot];
          if (entry[0]) begin
            if (entry[51:12] >= TABLE_PAGES) missing = 1;
            else page = int'(entry[51:12]);
          end else if (fn != FN_MAP) begin
            missing = 1;
          end else if (free_page >= TABLE_PAGES) begin
            oom = 1;
          end else begin
            tables[slot] = {12'b0, 40'(free_page), LINK_FLAGS};
            page = int'(free_page);
            free_page++;
          end
        end
        if (oom) begin
          st = STAT_OOM;
        end else if (missing) begin
          st = STAT_MISSING;
        end else begin
          slot = page * ENTRIES_PER_TABLE + int'(va[20:12]);
          if (fn == FN_MAP) begin
            tables[slot] = {12'b0, pa[51:12], flags};
          end else if (fn == FN_UNMAP) begin
            tables[slot] = '0;
          end else if (tables[slot][0]) begin
            phys = {tables[slot][51:12], 12'b0};
          end else begin
            st = STAT_MISSING;
          end
        end
      end
      status_count[st]++;
      expected_phys_q.push_back(phys);
      expected_status_q.push_back(st);
    endfunction

    function void check_response(logic [51:0] phys, logic [1:0] st);
      logic [51:0] want_phys;
      logic [1:0]  want_st;
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: unexpected response phys=%h status=%0d", $realtime, phys, st);
        return;
      end
      want_phys = expected_phys_q.pop_front();
      want_st   = expected_status_q.pop_front();
      checked++;
      if (phys !== want_phys || st !== want_st) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("%0t: mismatch phys exp=%h act=%h, status exp=%0d act=%0d",
                   $realtime, want_phys, phys, want_st, st);
      end
    endfunction

    function int pending();
      return expected_status_q.size();
    endfunction

    function bit failed();
      return mismatches != 0 || expected_status_q.size() != 0;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  func_i;
  logic [47:0] virt_addr_i;
  logic [51:0] phys_addr_i;
  logic [11:0] page_flags_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [51:0] result_phys_o;
  logic [1:0]  status_o;

  page_walk_checker board = new();
  bit          quiet = 1'b0;
  bit          hold_request = 1'b0;
  int          sent_count = 0;
  int          idle_cycles = 0;
  logic [47:0] recent_va [$];

  four_level_page_table_walker_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .virt_addr_i  (virt_addr_i),
    .phys_addr_i  (phys_addr_i),
    .page_flags_i (page_flags_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_phys_o(result_phys_o),
    .status_o     (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_response(result_phys_o, status_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d cycles without a transaction", idle_cycles);
      $display("[four_level_page_table_walker_core] ERROR");
      $finish;
    end
  end

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i  = 1'b0;
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_request(input logic [1:0] fn, input logic [47:0] va,
                              input logic [51:0] pa, input logic [11:0] flags);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    func_i       = fn;
    virt_addr_i  = va;
    phys_addr_i  = pa;
    page_flags_i = flags;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(fn, va, pa, flags);
    sent_count++;
  endtask

  function automatic logic [8:0] pick_index();
    case ($urandom_range(0, 5))
      0:       return 9'd0;
      1:       return 9'd511;
      2:       return 9'd170;
      3:       return 9'd341;
      default: return 9'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] pick_va();
    return {pick_index(), pick_index(), pick_index(), pick_index(), 12'($urandom)};
  endfunction

  function automatic logic [51:0] random_phys();
    return 52'({$urandom, $urandom});
  endfunction

  task automatic run_directed();
    send_request(FN_LOOKUP, 48'h0, 52'h0, 12'h0);
    send_request(FN_UNMAP, 48'h0, 52'h0, 12'h0);
    send_request(FN_MAP, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
    send_request(FN_LOOKUP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0);
    send_request(FN_LOOKUP, 48'hFFFF_FFFF_F000, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
    send_request(FN_MAP, 48'h0, 52'h0, 12'h0);
    send_request(FN_LOOKUP, 48'h0, 52'h0, 12'h0);
    send_request(FN_UNMAP, 48'h0, 52'h0, 12'h0);
    send_request(FN_MAP, 48'h0000_0000_1FFF, 52'hA_5A5A_5A5A_5FFF, 12'h001);
    send_request(FN_LOOKUP, 48'h0000_0000_1000, 52'h0, 12'h0);
    send_request(FN_RESERVED, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 12'hFFF);
    send_request(FN_RESERVED, 48'h0, 52'h0, 12'h0);
    send_request(FN_MAP, 48'h8000_0000_0000, 52'h5_A5A5_A5A5_A000, 12'h007);
    send_request(FN_LOOKUP, 48'h8000_0000_0000, 52'h0, 12'h0);
    send_request(FN_LOOKUP, 48'h8000_4000_0000, 52'h0, 12'h0);
    send_request(FN_UNMAP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0);
    send_request(FN_LOOKUP, 48'hFFFF_FFFF_FFFF, 52'h0, 12'h0);
    send_request(FN_UNMAP, 48'h8000_0000_1000, 52'h0, 12'h0);
    send_request(FN_UNMAP, 48'h0000_0020_0000, 52'h0, 12'h0);
  endtask

  task automatic run_random();
    int          choice;
    bit          pressure_done;
    logic [47:0] va;
    logic [11:0] flags;
    pressure_done = 1'b0;
    while (sent_count < TOTAL_ITEMS) begin
      quiet = (sent_count >= TOTAL_ITEMS - QUIET_ITEMS);
      if (sent_count >= PRESSURE_AT && !pressure_done) begin
        hold_request  = 1'b1;
        pressure_done = 1'b1;
      end
      choice = $urandom_range(0, 9);
      if (recent_va.size() != 0 && $urandom_range(0, 2) == 0)
        va = {recent_va[$urandom_range(0, recent_va.size() - 1)][47:12], 12'($urandom)};
      else
        va = pick_va();
      if (choice <= 5) begin
        flags = 12'($urandom);
        if ($urandom_range(0, 7) != 0) flags[0] = 1'b1;
        send_request(FN_MAP, va, random_phys(), flags);
        recent_va.push_back(va);
        if (recent_va.size() > 32) void'(recent_va.pop_front());
        send_request(FN_LOOKUP, {va[47:12], 12'($urandom)}, random_phys(), 12'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          send_request(FN_UNMAP, {va[47:12], 12'($urandom)}, random_phys(), 12'($urandom));
          send_request(FN_LOOKUP, va, random_phys(), 12'($urandom));
        end
      end else if (choice <= 7) begin
        send_request(($urandom_range(0, 1) == 0) ? FN_UNMAP : FN_LOOKUP, va,
                     random_phys(), 12'($urandom));
      end else if (choice == 8) begin
        send_request(2'($urandom_range(0, 3)), 48'({$urandom, $urandom}), random_phys(),
                     12'($urandom));
      end else begin
        send_request(FN_LOOKUP, pick_va(), random_phys(), 12'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FN_MAP;
    virt_addr_i  = '0;
    phys_addr_i  = '0;
    page_flags_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    run_directed();
    run_random();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d requests: %0d map, %0d unmap, %0d lookup, %0d reserved; %0d responses checked",
             sent_count, board.func_count[FN_MAP], board.func_count[FN_UNMAP],
             board.func_count[FN_LOOKUP], board.func_count[FN_RESERVED], board.checked);
    $display("status ok %0d, missing %0d, out of pages %0d; %0d of %0d table pages allocated",
             board.status_count[STAT_OK], board.status_count[STAT_MISSING],
             board.status_count[STAT_OOM], board.free_page - 1, TABLE_PAGES - 1);
    if (!board.failed()) begin
      $display("[four_level_page_table_walker_core] OK");
    end else begin
      $display("%0d mismatches, %0d responses still outstanding", board.mismatches,
               board.pending());
      $display("[four_level_page_table_walker_core] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ptw_pkg.sv
rtl/core/ptw_ram.sv
rtl/core/ptw_walk.sv
rtl/core/four_level_page_table_walker_core.sv
tb/testbench.sv
